### hw/rtl/status_led_timed_blink_assert.svh
// Assertion macros shared by the status LED driver RTL.
// Included by slb_core and status_led_timed_blink; needs no package.
`ifndef STATUS_LED_TIMED_BLINK_ASSERT_SVH
`define STATUS_LED_TIMED_BLINK_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, skipped while reset is high
`define SLB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, skipped while reset is high
`define SLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SLB_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/slb_pkg.sv
// Types and codes for the status LED driver.
// Used by slb_core and status_led_timed_blink; depends on nothing.
package slb_pkg;

   localparam int FIELD_WIDTH = 16;

   // beat kind
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_BLINK = 2'd2
   } led_mode_type;

   // one input beat as held in the input register
   typedef struct packed {
      logic                   operation;
      logic [1:0]             led_mode;
      logic [FIELD_WIDTH-1:0] blink_duration_ms;
      logic [FIELD_WIDTH-1:0] blink_interval_ms;
   } slb_item_type;

endpackage

### hw/rtl/slb_core.sv
// LED state and per-beat update logic: commands, tick counting, blink expiry.
// Depends on slb_pkg and status_led_timed_blink_assert.svh.
`include "status_led_timed_blink_assert.svh"
module slb_core #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  slb_pkg::slb_item_type item,
   output logic                 level_in
);
   import slb_pkg::*;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   led_mode_type          active_mode_ff, active_mode_in;
   logic [TIME_WIDTH-1:0] active_dur_ff, active_dur_in;
   logic [TIME_WIDTH-1:0] active_ivl_ff, active_ivl_in;
   led_mode_type          saved_mode_ff, saved_mode_in;
   logic [TIME_WIDTH-1:0] saved_dur_ff, saved_dur_in;
   logic [TIME_WIDTH-1:0] saved_ivl_ff, saved_ivl_in;
   logic                  level_ff;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0] toggle_ff, toggle_in;

   logic [TIME_WIDTH-1:0] cmd_dur;
   logic [TIME_WIDTH-1:0] cmd_ivl;
   logic [TIME_WIDTH-1:0] elapsed_inc;
   logic [TIME_WIDTH-1:0] toggle_inc;

   // command fields held in TIME_WIDTH bits
   assign cmd_dur = TIME_WIDTH'(item.blink_duration_ms);
   assign cmd_ivl = TIME_WIDTH'(item.blink_interval_ms);

   // saturating counters
   assign elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign toggle_inc  = (toggle_ff == TIME_MAX) ? toggle_ff : toggle_ff + 1'b1;

   // next state for one beat
   always_comb begin
      active_mode_in = active_mode_ff;
      active_dur_in  = active_dur_ff;
      active_ivl_in  = active_ivl_ff;
      saved_mode_in  = saved_mode_ff;
      saved_dur_in   = saved_dur_ff;
      saved_ivl_in   = saved_ivl_ff;
      level_in       = level_ff;
      elapsed_in     = elapsed_ff;
      toggle_in      = toggle_ff;
      if (step_en) begin
         if (item.operation == OP_CMD) begin
            saved_mode_in = active_mode_ff;
            saved_dur_in  = active_dur_ff;
            saved_ivl_in  = active_ivl_ff;
            active_dur_in = cmd_dur;
            active_ivl_in = cmd_ivl;
            case (item.led_mode)
               MODE_ON: begin
                  active_mode_in = MODE_ON;
                  level_in       = 1'b1;
               end
               MODE_BLINK: begin
                  active_mode_in = MODE_BLINK;
                  level_in       = ~level_ff;
                  elapsed_in     = '0;
                  toggle_in      = '0;
               end
               default: begin
                  // off, and the unused code acts as off
                  active_mode_in = MODE_OFF;
                  level_in       = 1'b0;
               end
            endcase
         end else if (active_mode_ff == MODE_BLINK) begin
            elapsed_in = elapsed_inc;
            if (active_dur_ff != '0 && elapsed_inc >= active_dur_ff) begin
               // blink expired: fall back to a saved endless blink or to on, else go off
               if (saved_mode_ff == MODE_BLINK && saved_dur_ff == '0) begin
                  active_mode_in = saved_mode_ff;
                  active_dur_in  = saved_dur_ff;
                  active_ivl_in  = saved_ivl_ff;
                  level_in       = ~level_ff;
                  elapsed_in     = '0;
                  toggle_in      = '0;
               end else if (saved_mode_ff == MODE_ON) begin
                  active_mode_in = MODE_ON;
                  active_dur_in  = '0;
                  level_in       = 1'b1;
               end else begin
                  active_mode_in = MODE_OFF;
                  active_dur_in  = '0;
                  level_in       = 1'b0;
               end
            end else if (toggle_inc >= active_ivl_ff) begin
               level_in  = ~level_ff;
               toggle_in = '0;
            end else begin
               toggle_in = toggle_inc;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_mode_ff <= MODE_OFF;
         active_dur_ff  <= '0;
         active_ivl_ff  <= '0;
         saved_mode_ff  <= MODE_OFF;
         saved_dur_ff   <= '0;
         saved_ivl_ff   <= '0;
         level_ff       <= 1'b0;
         elapsed_ff     <= '0;
         toggle_ff      <= '0;
      end else begin
         active_mode_ff <= active_mode_in;
         active_dur_ff  <= active_dur_in;
         active_ivl_ff  <= active_ivl_in;
         saved_mode_ff  <= saved_mode_in;
         saved_dur_ff   <= saved_dur_in;
         saved_ivl_ff   <= saved_ivl_in;
         level_ff       <= level_in;
         elapsed_ff     <= elapsed_in;
         toggle_ff      <= toggle_in;
      end
   end

   `SLB_ASSERT_NEXT(a_cmd_saves, clock, reset, step_en && item.operation == OP_CMD,
      saved_mode_ff == $past(active_mode_ff), "command did not save active mode")
   `SLB_ASSERT_NEXT(a_blink_starts, clock, reset,
      step_en && item.operation == OP_CMD && item.led_mode == MODE_BLINK,
      level_ff != $past(level_ff) && elapsed_ff == '0, "blink start did not toggle")
   `SLB_ASSERT_NEXT(a_idle_tick, clock, reset,
      step_en && item.operation == OP_TICK && active_mode_ff != MODE_BLINK,
      $stable(level_ff) && $stable(active_mode_ff), "tick changed a steady LED")
endmodule

### hw/rtl/status_led_timed_blink.sv
// Status LED driver with timed blinking: input register, slb_core, result register.
// Depends on slb_pkg, slb_core and status_led_timed_blink_assert.svh.
//
// Usage:
//  - req_ channel: one beat is either a millisecond tick (req_operation = 0)
//    or a command (req_operation = 1) with mode off / on / blink, a blink
//    duration (0 = forever) and a blink interval, both in ticks.
//  - rsp_ channel: exactly one beat per request, rsp_led_level = LED level
//    after that request, in request order.
//  - Path: an accepted request passes the input register, then the result register,
//    before its result shows on rsp_ (a held rsp_stall can stall it in between).
//  - Throughput: one request per cycle while rsp_stall is low; the state update
//    is a single pass of counter increment and compare between the two registers.
//  - Stall: when rsp_stall holds a waiting result, one more request is still
//    taken into the input register; req_stall rises only when both are full.
//  - Reset (synchronous): LED off, no saved status, counters zero, both
//    register stages empty.
`include "status_led_timed_blink_assert.svh"
module status_led_timed_blink #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [1:0]                           req_led_mode,
   input  logic [slb_pkg::FIELD_WIDTH-1:0]      req_blink_duration_ms,
   input  logic [slb_pkg::FIELD_WIDTH-1:0]      req_blink_interval_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_led_level
);
   import slb_pkg::*;

   slb_item_type item_ff, item_in;
   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic         level_ff, level_in;
   logic         core_level;
   logic         advance;
   logic         req_take;
   logic         rsp_take;

   // handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_take ? 1'b0 : out_valid_ff);
   assign level_in     = advance ? core_level : level_ff;

   // input register payload
   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.operation         = req_operation;
         item_in.led_mode          = req_led_mode;
         item_in.blink_duration_ms = req_blink_duration_ms;
         item_in.blink_interval_ms = req_blink_interval_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      level_ff <= level_in;
   end

   // state update, one beat per advance
   slb_core #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .level_in(core_level)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_led_level = level_ff;

   `SLB_ASSERT_NEXT(a_advance_loads, clock, reset, advance, rsp_valid,
      "result register not loaded")
   `SLB_ASSERT_SAME(a_stall_when_full, clock, reset, req_stall,
      in_valid_ff && rsp_valid && rsp_stall, "request stalled with room left")
   `SLB_ASSERT_NEXT(a_hold_item, clock, reset, in_valid_ff && rsp_valid && rsp_stall,
      in_valid_ff && $stable(item_ff), "held request lost")
endmodule

### verif/status_led_timed_blink_tb.sv
// Self-checking testbench for the status LED driver with timed blinking.
// Needs slb_pkg and the status_led_timed_blink RTL; reads no files.
module status_led_timed_blink_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import slb_pkg::*;

   localparam int         TW           = FIELD_WIDTH;
   localparam int         RANDOM_BEATS = 400;
   localparam int         QUIET_LIMIT  = 4000;
   localparam int         REPORT_MAX   = 10;
   localparam logic [1:0] MODE_SPARE   = 2'd3;   // unassigned code, behaves as off

   typedef logic [TW-1:0] ms_count_type;

   logic          clock                 = 1'b0;
   logic          reset                 = 1'b1;
   logic          req_valid             = 1'b0;
   logic          req_operation         = 1'b0;
   logic [1:0]    req_led_mode          = 2'b00;
   ms_count_type  req_blink_duration_ms = '0;
   ms_count_type  req_blink_interval_ms = '0;
   logic          rsp_stall             = 1'b0;
   logic          req_stall;
   logic          rsp_valid;
   logic          rsp_led_level;

   status_led_timed_blink u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_led_mode          (req_led_mode),
      .req_blink_duration_ms (req_blink_duration_ms),
      .req_blink_interval_ms (req_blink_interval_ms),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_led_level         (rsp_led_level)
   );

   always #4 clock = ~clock;

   // beats waiting to be offered, the beat on the bus, LED levels still due
   slb_item_type  beat_queue[$];
   slb_item_type  beat_on_bus;
   logic          led_due[$];
   logic          level_want;

   int unsigned   total_beats    = 1;
   int unsigned   beats_taken    = 0;
   int unsigned   levels_checked = 0;
   int unsigned   mismatches     = 0;
   int unsigned   cmd_count      = 0;
   int unsigned   tick_count     = 0;
   int unsigned   expiries       = 0;
   int unsigned   quiet_cycles   = 0;

   // LED status model: what is in force now, what to return to, counters
   led_mode_type  cur_mode     = MODE_OFF;
   led_mode_type  prev_mode    = MODE_OFF;
   ms_count_type  cur_dur      = '0;
   ms_count_type  cur_ivl      = '0;
   ms_count_type  prev_dur     = '0;
   ms_count_type  prev_ivl     = '0;
   ms_count_type  since_start  = '0;
   ms_count_type  since_toggle = '0;
   logic          lit          = 1'b0;

   function automatic ms_count_type sat_up(input ms_count_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // advance the LED model by one accepted beat and queue the level it leaves
   task automatic led_model_step(input slb_item_type it);
      if (it.operation == OP_CMD) begin
         cmd_count++;
         prev_mode = cur_mode;
         prev_dur  = cur_dur;
         prev_ivl  = cur_ivl;
         cur_dur   = it.blink_duration_ms;
         cur_ivl   = it.blink_interval_ms;
         case (it.led_mode)
            MODE_ON: begin
               cur_mode = MODE_ON;
               lit      = 1'b1;
            end
            MODE_BLINK: begin
               cur_mode     = MODE_BLINK;
               lit          = ~lit;
               since_start  = '0;
               since_toggle = '0;
            end
            default: begin
               cur_mode = MODE_OFF;
               lit      = 1'b0;
            end
         endcase
      end else begin
         tick_count++;
         if (cur_mode == MODE_BLINK) begin
            since_start = sat_up(since_start);
            if (cur_dur != '0 && since_start >= cur_dur) begin
               // blink ran out: fall back to a saved endless blink or to on, else go off
               expiries++;
               if (prev_mode == MODE_BLINK && prev_dur == '0) begin
                  cur_mode     = prev_mode;
                  cur_dur      = prev_dur;
                  cur_ivl      = prev_ivl;
                  lit          = ~lit;
                  since_start  = '0;
                  since_toggle = '0;
               end else if (prev_mode == MODE_ON) begin
                  cur_mode = MODE_ON;
                  cur_dur  = '0;
                  lit      = 1'b1;
               end else begin
                  cur_mode = MODE_OFF;
                  cur_dur  = '0;
                  lit      = 1'b0;
               end
            end else begin
               since_toggle = sat_up(since_toggle);
               if (since_toggle >= cur_ivl) begin
                  lit          = ~lit;
                  since_toggle = '0;
               end
            end
         end
      end
      led_due.push_back(lit);
   endtask

   task automatic queue_cmd(input logic [1:0] mode, input ms_count_type dur,
                            input ms_count_type ivl);
      slb_item_type it;
      it.operation         = OP_CMD;
      it.led_mode          = mode;
      it.blink_duration_ms = dur;
      it.blink_interval_ms = ivl;
      beat_queue.push_back(it);
   endtask

   // ticks carry random junk in the unused fields
   task automatic queue_ticks(input int n);
      slb_item_type it;
      repeat (n) begin
         it.operation         = OP_TICK;
         it.led_mode          = 2'($urandom);
         it.blink_duration_ms = ms_count_type'($urandom);
         it.blink_interval_ms = ms_count_type'($urandom);
         beat_queue.push_back(it);
      end
   endtask

   // 0: sender sparse gaps, receiver heavy stall; 1: the reverse; 2: full rate
   function automatic int idle_phase();
      int p;
      p = (beats_taken * 3) / total_beats;
      return (p > 2) ? 2 : p;
   endfunction

   function automatic logic sender_gap();
      case (idle_phase())
         0:       return $urandom_range(0, 99) < 24;
         1:       return $urandom_range(0, 99) < 88;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_hold();
      case (idle_phase())
         0:       return $urandom_range(0, 99) < 88;
         1:       return $urandom_range(0, 99) < 24;
         default: return 1'b0;
      endcase
   endfunction

   // request driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            led_model_step(beat_on_bus);
            beats_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (beat_queue.size() != 0 && !sender_gap()) begin
               beat_on_bus = beat_queue.pop_front();
               req_operation         <= beat_on_bus.operation;
               req_led_mode          <= beat_on_bus.led_mode;
               req_blink_duration_ms <= beat_on_bus.blink_duration_ms;
               req_blink_interval_ms <= beat_on_bus.blink_interval_ms;
               req_valid             <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each LED level beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (led_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected LED beat: level %0b with nothing pending",
                           rsp_led_level);
            end else begin
               level_want = led_due.pop_front();
               levels_checked++;
               if (rsp_led_level !== level_want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("LED level mismatch at beat %0d: expected %0b, got %0b",
                              levels_checked, level_want, rsp_led_level);
               end
            end
         end
         rsp_stall <= receiver_hold();
      end
   end

   // watchdog on cycles where neither channel moves a beat
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
            $display("[status_led_timed_blink] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int            directed_beats;
      int            pick;
      int            ticks;
      logic [1:0]    base;
      ms_count_type  dur;
      ms_count_type  ivl;

      // directed: idle tick, on, spare mode, every-tick blink
      queue_ticks(1);
      queue_cmd(MODE_ON, ms_count_type'($urandom), ms_count_type'($urandom));
      queue_ticks(1);
      queue_cmd(MODE_SPARE, ms_count_type'($urandom), ms_count_type'($urandom));
      queue_cmd(MODE_BLINK, '0, '0);
      queue_ticks(2);
      // short blink over an endless one: expiry resumes the endless blink
      queue_cmd(MODE_BLINK, 16'd3, 16'd1);
      queue_ticks(4);
      // blink over on: expiry relights the LED
      queue_cmd(MODE_ON, '0, '0);
      queue_cmd(MODE_BLINK, 16'd2, '1);
      queue_ticks(2);
      // finite blink over finite blink: expiry goes dark
      queue_cmd(MODE_BLINK, 16'd2, 16'd2);
      queue_cmd(MODE_BLINK, 16'd1, '0);
      queue_ticks(1);
      // widest duration and interval
      queue_cmd(MODE_BLINK, '1, '1);
      queue_ticks(1);
      queue_cmd(MODE_OFF, '0, '0);
      directed_beats = beat_queue.size();

      // random: mostly base status, finite blink, ticks around its expiry
      while (beat_queue.size() < directed_beats + RANDOM_BEATS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            if ($urandom_range(0, 1) == 1) begin
               base = 2'($urandom_range(0, 2));
               queue_cmd(base,
                         (base == MODE_BLINK) ? ms_count_type'(0) : ms_count_type'($urandom),
                         ms_count_type'($urandom_range(0, 4)));
            end
            if ($urandom_range(0, 7) == 0) begin
               dur   = ms_count_type'($urandom);
               ivl   = ms_count_type'($urandom);
               ticks = $urandom_range(1, 6);
            end else begin
               dur   = ms_count_type'($urandom_range(1, 12));
               ivl   = ms_count_type'($urandom_range(0, 5));
               ticks = $urandom_range(0, int'(dur) + 6);
            end
            queue_cmd(MODE_BLINK, dur, ivl);
            queue_ticks(ticks);
         end else if (pick <= 8) begin
            queue_ticks($urandom_range(1, 8));
         end else begin
            queue_cmd(2'($urandom_range(0, 3)), ms_count_type'($urandom),
                      ms_count_type'($urandom));
         end
      end
      total_beats = beat_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: every beat offered and taken, every level seen, then a margin
      while (beat_queue.size() != 0 || req_valid) @(posedge clock);
      while (led_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d LED levels over %0d beats: %0d commands, %0d ticks.",
               levels_checked, beats_taken, cmd_count, tick_count);
      $display("Blink expiries seen: %0d; failures: %0d.", expiries, mismatches);
      if (mismatches == 0 && led_due.size() == 0) begin
         $display("[status_led_timed_blink] OK");
      end else begin
         $display("[status_led_timed_blink] ERROR");
      end
      $finish;
   end

endmodule
